@@ sv/psd_pkg.sv @@
`timescale 1ns / 1ps

package psd_pkg;

	localparam int MAX_NODES   = 8;
	localparam int IDX_W       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W       = $clog2(MAX_NODES + 1);

	localparam int COORD_W     = 16;
	localparam int NODE_W      = 3 * COORD_W;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int SQR_W       = 2 * DIFF_W;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int SQ_W        = 34;
	localparam int DIAM_W      = 17;
	localparam int DIM_W       = 2;
	localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// root iteration starts at bit 2*SQRT_TOP, the top power of four below 2^SQ_W
	localparam int SQRT_TOP    = SQ_W / 2 - 1;
	localparam int SQRT_K_W    = $clog2(SQRT_TOP + 1);
	localparam int ROOT_W      = SQ_W + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      last_node;
	} node_word_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CMP   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_SQRT  = 4'b1000
	} back_state_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] value;
	} root_req_t;

	typedef struct packed {
		logic              busy;
		logic [DIAM_W-1:0] root;
	} root_rsp_t;

endpackage

@@ sv/psd_ram.sv @@
`timescale 1ns / 1ps

module psd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/psd_front.sv @@
`timescale 1ns / 1ps

module psd_front import psd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      node_valid,
	output logic                      node_stall,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic                      last_node,
	output logic                      q_valid,
	output node_word_t                q_word,
	input  logic                      q_pop
);

	node_word_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              push;
	node_word_t        in_word;

	assign node_stall = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = node_valid && !node_stall;
	assign q_valid    = (fill_q != '0);
	assign q_word     = entry_q[rd_ptr_q];

	always_comb begin
		in_word.coord_x   = coord_x;
		in_word.coord_y   = coord_y;
		in_word.coord_z   = coord_z;
		in_word.last_node = last_node;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/psd_isqrt.sv @@
`timescale 1ns / 1ps

module psd_isqrt import psd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  root_req_t req,
	output root_rsp_t rsp
);

	logic [SQ_W-1:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SQRT_K_W-1:0] k_q;
	logic                busy_q;
	logic [ROOT_W-1:0]   bit_w;
	logic [ROOT_W-1:0]   trial;
	logic                fits;

	assign bit_w = ROOT_W'(1) << {k_q, 1'b0};
	assign trial = root_q + bit_w;
	assign fits  = ({1'b0, rem_q} >= trial);

	assign rsp.busy = busy_q;
	assign rsp.root = root_q[DIAM_W-1:0];

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.value;
			root_q <= '0;
			k_q    <= SQRT_K_W'(SQRT_TOP);
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= rem_q - trial[SQ_W-1:0];
				root_q <= (root_q >> 1) + bit_w;
			end else begin
				root_q <= root_q >> 1;
			end
			k_q <= k_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && k_q == '0) begin
			busy_q <= 1'b0;
		end
	end

endmodule

@@ sv/psd_back.sv @@
`timescale 1ns / 1ps

module psd_back import psd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DIM_W-1:0]  space_dimension,
	input  logic              q_valid,
	input  node_word_t        q_word,
	output logic              q_pop,
	output root_req_t         root_req,
	input  root_rsp_t         root_rsp,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [DIAM_W-1:0] diameter,
	output logic [SQ_W-1:0]   max_dist_squared,
	output logic              node_overflow
);

	back_state_t      state_q;
	node_word_t       cur_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cmp_n_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [SQ_W-1:0]  best_q;
	logic             ovf_q;
	logic             result_valid_q;

	logic                      has_room;
	logic                      rd_en;
	logic                      drained;
	logic                      emit;
	logic [NODE_W-1:0]         wdata;
	logic [NODE_W-1:0]         rdata;
	logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;
	logic signed [DIFF_W-1:0]  dx, dy, dz;
	logic signed [SQR_W-1:0]   sqx, sqy, sqz;
	logic                      use_y, use_z;
	logic [SQ_W-1:0]           sum;

	logic              v_s1;
	logic              v_s2;
	logic [PROD_W-1:0] px_s2, py_s2, pz_s2;

	assign has_room = (count_q < CNT_W'(MAX_NODES));
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign rd_en    = (state_q == ST_CMP);
	assign drained  = !v_s1 && !v_s2;
	assign emit     = (state_q == ST_SQRT) && !root_rsp.busy
		&& (!result_valid_q || !result_stall);

	assign wdata = {q_word.coord_x, q_word.coord_y, q_word.coord_z};

	psd_ram #(
		.WIDTH (NODE_W),
		.DEPTH (MAX_NODES)
	) u_store (
		.clk   (clk),
		.we    (q_pop && has_room),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign root_req.value = best_q;
	assign root_req.start =
		(q_pop && q_word.last_node && !(has_room && count_q != '0))
		|| ((state_q == ST_DRAIN) && drained && cur_q.last_node);

	// dimension 0 behaves as 1
	assign use_y = space_dimension[1];
	assign use_z = &space_dimension;

	assign {rd_x, rd_y, rd_z} = rdata;
	assign dx  = DIFF_W'(cur_q.coord_x) - DIFF_W'(rd_x);
	assign dy  = DIFF_W'(cur_q.coord_y) - DIFF_W'(rd_y);
	assign dz  = DIFF_W'(cur_q.coord_z) - DIFF_W'(rd_z);
	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign sqz = dz * dz;
	assign sum = SQ_W'(px_s2) + SQ_W'(py_s2) + SQ_W'(pz_s2);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			px_s2 <= sqx[PROD_W-1:0];
			py_s2 <= use_y ? sqy[PROD_W-1:0] : '0;
			pz_s2 <= use_z ? sqz[PROD_W-1:0] : '0;
		end
		if (q_pop) begin
			cur_q <= q_word;
		end
		if (emit) begin
			diameter         <= root_rsp.root;
			max_dist_squared <= best_q;
			node_overflow    <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			cmp_n_q        <= '0;
			rd_idx_q       <= '0;
			best_q         <= '0;
			ovf_q          <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;

			if (emit) begin
				best_q <= '0;
			end else if (v_s2 && sum > best_q) begin
				best_q <= sum;
			end

			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (has_room) begin
							count_q  <= count_q + 1'b1;
							cmp_n_q  <= count_q;
							rd_idx_q <= '0;
							if (count_q != '0) begin
								state_q <= ST_CMP;
							end else if (q_word.last_node) begin
								state_q <= ST_SQRT;
							end
						end else begin
							ovf_q <= 1'b1;
							if (q_word.last_node) begin
								state_q <= ST_SQRT;
							end
						end
					end
				end
				ST_CMP: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == cmp_n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						state_q <= cur_q.last_node ? ST_SQRT : ST_IDLE;
					end
				end
				ST_SQRT: begin
					if (emit) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;

endmodule

@@ sv/point_set_diameter_unit.sv @@
`timescale 1ns / 1ps
// Node word with n nodes already stored: the compare engine reads one stored node per cycle
// from the node RAM into a three-stage distance pipe; the first node needs no compare.
// The last word of an element then runs the one-bit-per-cycle square root and loads the
// result register.
// A two-word input queue lets nodes arrive while the engine or the result register is busy.
// Reset (arst_n low, asynchronous): element cleared, queue empty, no result, dimension 3.
// Node RAM contents are not reset; only entries written for the current element are read.

module point_set_diameter_unit import psd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [DIM_W-1:0]          cfg_wr_data,
	input  logic                      node_valid,
	output logic                      node_stall,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic                      last_node,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [DIAM_W-1:0]         diameter,
	output logic [SQ_W-1:0]           max_dist_squared,
	output logic                      node_overflow
);

	logic [DIM_W-1:0] space_dimension_q;
	logic             q_valid;
	logic             q_pop;
	node_word_t       q_word;
	root_req_t        root_req;
	root_rsp_t        root_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_dimension_q <= DIM_RESET;
		end else if (cfg_wr_en) begin
			space_dimension_q <= cfg_wr_data;
		end
	end

	psd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.node_stall (node_stall),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.last_node  (last_node),
		.q_valid    (q_valid),
		.q_word     (q_word),
		.q_pop      (q_pop)
	);

	psd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.space_dimension  (space_dimension_q),
		.q_valid          (q_valid),
		.q_word           (q_word),
		.q_pop            (q_pop),
		.root_req         (root_req),
		.root_rsp         (root_rsp),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.diameter         (diameter),
		.max_dist_squared (max_dist_squared),
		.node_overflow    (node_overflow)
	);

	psd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

endmodule

@@ sv/psd_checker.sv @@
`timescale 1ns / 1ps

module psd_checker import psd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input logic [DIAM_W-1:0] diameter,
	input logic [SQ_W-1:0]   max_dist_squared,
	input logic              node_overflow
);

	localparam int CHK_W = 2 * (DIAM_W + 1);

	logic [CHK_W-1:0] d_lo;
	logic [CHK_W-1:0] d_hi;
	logic [CHK_W-1:0] sq_ext;

	assign d_lo   = CHK_W'(diameter);
	assign d_hi   = CHK_W'(diameter) + 1'b1;
	assign sq_ext = CHK_W'(max_dist_squared);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(diameter)
			&& $stable(max_dist_squared) && $stable(node_overflow))
		else $error("result word changed while stalled");

	a_root_low: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (d_lo * d_lo) <= sq_ext)
		else $error("diameter squared exceeds max distance");

	a_root_high: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (d_hi * d_hi) > sq_ext)
		else $error("diameter below floor root");

	a_reset: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid right after reset");

endmodule

bind point_set_diameter_unit psd_checker u_psd_checker (.*);
